>>> hdl/fbfl_pkg.sv
`timescale 1ns / 1ps

package fbfl_pkg;

   localparam int unsigned MAX_BLOCKS_DEF = 256;
   localparam int unsigned BLOCK_W = 8;
   localparam int unsigned COUNT_W = 9;
   localparam int unsigned LIST_LIMIT = 256;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_FREE  = 2'd2;
   localparam logic [1:0] MODE_QUERY = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd1;
   localparam logic [1:0] STATUS_FREED   = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   typedef struct packed {
      logic [BLOCK_W-1:0] blk;
      logic [COUNT_W-1:0] free_count;
      logic               cmp_en;
      logic               remove_en;
      logic               append_en;
   } cell_ctrl_type;

endpackage

>>> hdl/fixed_block_free_list_unit.sv
`timescale 1ns / 1ps
// flow: a request runs a compare pass (match state), then an update pass (update state)
// through the cell chain; the response beat is registered as the update fires, held off
// by a stalled response; a new request is taken only once the last one's update fires
// reset: synchronous, clears block and free counts so the list reads empty;
// list entries are not cleared and no clearing pass is run

module fixed_block_free_list_unit #(
   parameter int unsigned MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_mode,
   input  logic [fbfl_pkg::BLOCK_W-1:0]   req_block_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [fbfl_pkg::COUNT_W-1:0]   rsp_block_count,
   output logic [fbfl_pkg::COUNT_W-1:0]   rsp_free_count,
   output logic [fbfl_pkg::BLOCK_W-1:0]   rsp_first_free,
   output logic                           rsp_has_free
);
   import fbfl_pkg::*;

   localparam int unsigned NCELLS = (MAX_BLOCKS < LIST_LIMIT) ? MAX_BLOCKS : LIST_LIMIT;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_MATCH  = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         mode_ff, mode_in;
   logic [BLOCK_W-1:0] blk_ff, blk_in;
   logic [COUNT_W-1:0] block_count_ff, block_count_in;
   logic [COUNT_W-1:0] free_count_ff, free_count_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_fire;
   logic               upd_fire;
   logic               found;
   logic               write_ok;
   logic               free_ok;
   logic [1:0]         status_c;
   logic [COUNT_W-1:0] blk_ext;
   cell_ctrl_type      ctrl;

   logic [BLOCK_W-1:0] entries [NCELLS];
   logic [NCELLS:0]    shift_chain;
   logic [NCELLS-1:0]  match_vec;

   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_UPDATE) && upd_fire));
   assign req_fire  = req_valid && !req_stall;
   assign upd_fire  = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign found     = |match_vec;
   assign blk_ext   = {1'b0, blk_ff};

   // request decode against the counts and the chain match
   always_comb begin
      status_c = STATUS_OK;
      write_ok = 1'b0;
      free_ok  = 1'b0;
      case (mode_ff)
         MODE_WRITE: begin
            if (blk_ext > block_count_ff) begin
               status_c = STATUS_MISSING;
            end else if ((blk_ext == block_count_ff) &&
                         (32'(block_count_ff) >= MAX_BLOCKS)) begin
               status_c = STATUS_FULL;
            end else begin
               write_ok = 1'b1;
            end
         end
         MODE_READ: begin
            if (blk_ext >= block_count_ff) begin
               status_c = STATUS_MISSING;
            end else if (found) begin
               status_c = STATUS_FREED;
            end
         end
         MODE_FREE: begin
            if (blk_ext >= block_count_ff) begin
               status_c = STATUS_MISSING;
            end else if (found) begin
               status_c = STATUS_FREED;
            end else if (32'(free_count_ff) >= MAX_BLOCKS) begin
               status_c = STATUS_FULL;
            end else begin
               free_ok = 1'b1;
            end
         end
         default: begin
            status_c = STATUS_OK;
         end
      endcase
   end

   always_comb begin
      ctrl.blk        = blk_ff;
      ctrl.free_count = free_count_ff;
      ctrl.cmp_en     = (state_ff == ST_MATCH);
      ctrl.remove_en  = upd_fire && write_ok && found;
      ctrl.append_en  = upd_fire && free_ok;
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      blk_in         = blk_ff;
      block_count_in = block_count_ff;
      free_count_in  = free_count_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (upd_fire) begin
               status_in    = status_c;
               rsp_valid_in = 1'b1;
               if (write_ok) begin
                  if (found) begin
                     free_count_in = free_count_ff - COUNT_W'(1);
                  end
                  if (blk_ext == block_count_ff) begin
                     block_count_in = block_count_ff + COUNT_W'(1);
                  end
               end
               if (free_ok) begin
                  free_count_in = free_count_ff + COUNT_W'(1);
               end
               state_in = req_fire ? ST_MATCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (req_fire) begin
         mode_in = req_mode;
         blk_in  = req_block_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         block_count_ff <= '0;
         free_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         block_count_ff <= block_count_in;
         free_count_ff  <= free_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      blk_ff    <= blk_in;
      status_ff <= status_in;
   end

   assign shift_chain[0] = 1'b0;

   for (genvar i = 0; i < NCELLS; i++) begin : g_cell
      logic [BLOCK_W-1:0] entry_next;
      if (i == NCELLS - 1) begin : g_last
         assign entry_next = entries[i];
      end else begin : g_mid
         assign entry_next = entries[i+1];
      end
      fbfl_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .entry_next (entry_next),
         .shift_in   (shift_chain[i]),
         .shift_out  (shift_chain[i+1]),
         .match      (match_vec[i]),
         .entry      (entries[i])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_block_count = block_count_ff;
   assign rsp_free_count  = free_count_ff;
   assign rsp_has_free    = (free_count_ff != '0);
   assign rsp_first_free  = rsp_has_free ? entries[0] : '0;

`ifndef SYNTHESIS
   a_free_le_blocks: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= block_count_ff)
      else $error("free count exceeds block count");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one free list cell matched");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response beat raised outside update");

   a_blocks_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> block_count_ff >= $past(block_count_ff))
      else $error("block count decreased");
`endif

endmodule

>>> hdl/fbfl_cell.sv
`timescale 1ns / 1ps

module fbfl_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fbfl_pkg::cell_ctrl_type        ctrl,
   input  logic [fbfl_pkg::BLOCK_W-1:0]   entry_next,
   input  logic                           shift_in,
   output logic                           shift_out,
   output logic                           match,
   output logic [fbfl_pkg::BLOCK_W-1:0]   entry
);
   import fbfl_pkg::*;

   localparam logic [COUNT_W-1:0] IDX = COUNT_W'(INDEX);

   logic [BLOCK_W-1:0] entry_ff;
   logic [BLOCK_W-1:0] entry_in;
   logic               match_ff;
   logic               match_in;
   logic               occupied;

   assign occupied  = ctrl.free_count > IDX;
   assign shift_out = shift_in | match_ff;

   always_comb begin
      match_in = match_ff;
      if (ctrl.cmp_en) begin
         match_in = occupied && (entry_ff == ctrl.blk);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.remove_en && shift_out) begin
         entry_in = entry_next;
      end else if (ctrl.append_en && (ctrl.free_count == IDX)) begin
         entry_in = ctrl.blk;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match = match_ff;
   assign entry = entry_ff;

endmodule
